[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of i_clk outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/rc4_pkg.sv]
`default_nettype none

package rc4_pkg;

    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned KEY_MAX    = 256;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 9;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam t_byte LAST_STEP = t_byte'(PERM_DEPTH - 1);

endpackage

`default_nettype wire

[rtl/core/rc4_keystream_cipher.sv]
// A key byte is taken while the block stays idle; a final key byte starts the key schedule.
// A data byte takes one read-modify-write pass over the permutation memory with one read and
// one write port; o_stall holds the input until the pass ends and the result is taken.
// Reset is synchronous: the permutation valid bits clear at once, so the
// permutation reads as identity, with no clearing pass; key length and indices clear.
`default_nettype none

`include "assert_macros.svh"

module rc4_keystream_cipher
    import rc4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B
    } t_state;

    t_state r_state;
    logic   r_mode_data;
    t_byte  r_i;
    t_byte  r_j;
    t_byte  r_addr_a;
    t_byte  r_kidx;
    t_len   r_key_len;
    t_len   r_sched_len;
    t_byte  r_sa;
    t_byte  r_sb;
    t_byte  r_byte;
    logic   r_out_valid;
    t_byte  r_out_byte;

    t_byte  r_perm_mem [PERM_DEPTH];
    t_byte  r_key_mem  [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] r_pvalid;
    t_byte  r_perm_q;
    t_byte  r_rd_addr;
    logic   r_rd_vld;
    t_byte  r_key_q;

    logic   accept;
    logic   key_store_en;
    t_len   len_inc;
    logic   perm_clr;
    logic   rd_en;
    t_byte  rd_addr;
    logic   wr_en;
    t_byte  wr_addr;
    t_byte  wr_data;
    t_byte  perm_eff;
    t_byte  n_j;
    t_byte  ks;
    logic   out_load;
    logic   out_free;
    t_len   n_kidx;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

    assign accept       = i_valid && (r_state == S_IDLE);
    assign key_store_en = accept && (i_command == CMD_KEY) && (r_key_len < t_len'(KEY_MAX));
    assign len_inc      = r_key_len + t_len'(key_store_en);
    assign perm_clr     = accept && (i_command == CMD_KEY) && i_last;
    assign perm_eff     = r_rd_vld ? r_perm_q : r_rd_addr;
    assign out_free     = !r_out_valid || !i_stall;
    assign out_load     = (r_state == S_WR_B) && r_mode_data && out_free;
    assign n_kidx       = {1'b0, r_kidx} + t_len'(1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr_a;
        wr_en   = 1'b0;
        wr_addr = r_addr_a;
        wr_data = perm_eff;
        n_j     = r_j;
        ks      = perm_eff;
        case (r_state)
            S_RD_A: begin
                rd_en = 1'b1;
            end
            S_RD_B: begin
                n_j     = r_j + perm_eff + (r_mode_data ? t_byte'(0) : r_key_q);
                rd_en   = 1'b1;
                rd_addr = n_j;
            end
            S_WR_A: begin
                wr_en   = 1'b1;
                wr_data = perm_eff;
                rd_en   = r_mode_data;
                rd_addr = r_sa + perm_eff;
            end
            S_WR_B: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_sa;
                if (r_rd_addr == r_j) begin
                    ks = r_sa;
                end else if (r_rd_addr == r_addr_a) begin
                    ks = r_sb;
                end else begin
                    ks = perm_eff;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_perm_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_perm_q  <= r_perm_mem[rd_addr];
            r_rd_addr <= rd_addr;
            r_rd_vld  <= r_pvalid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
        end else if (perm_clr) begin
            r_pvalid <= '0;
        end else if (wr_en) begin
            r_pvalid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_store_en) begin
            r_key_mem[r_key_len[BYTE_W-1:0]] <= i_data_byte;
        end
        if (r_state == S_RD_A) begin
            r_key_q <= r_key_mem[r_kidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode_data <= 1'b1;
            r_i         <= '0;
            r_j         <= '0;
            r_addr_a    <= '0;
            r_kidx      <= '0;
            r_key_len   <= '0;
            r_sched_len <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_byte ^ ks;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_command == CMD_DATA) begin
                            r_mode_data <= 1'b1;
                            r_i         <= r_i + t_byte'(1);
                            r_addr_a    <= r_i + t_byte'(1);
                            r_byte      <= i_data_byte;
                            r_state     <= S_RD_A;
                        end else if (i_last) begin
                            r_mode_data <= 1'b0;
                            r_sched_len <= len_inc;
                            r_key_len   <= '0;
                            r_addr_a    <= '0;
                            r_kidx      <= '0;
                            r_j         <= '0;
                            r_state     <= S_RD_A;
                        end else begin
                            r_key_len <= len_inc;
                        end
                    end
                end
                S_RD_A: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_sa    <= perm_eff;
                    r_j     <= n_j;
                    r_state <= S_WR_A;
                end
                S_WR_A: begin
                    r_sb    <= perm_eff;
                    r_state <= S_WR_B;
                end
                S_WR_B: begin
                    if (r_mode_data) begin
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_addr_a == LAST_STEP) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr_a <= r_addr_a + t_byte'(1);
                        r_kidx   <= (n_kidx == r_sched_len) ? '0 : n_kidx[BYTE_W-1:0];
                        r_state  <= S_RD_A;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_out_from_data, $rose(o_valid) |-> $past(out_load), "Result without data.")
    `ASSERT_NEVER(a_key_len_max, r_key_len > t_len'(KEY_MAX), "Key length exceeds its maximum.")
    `ASSERT_NEVER(a_sched_len, !r_mode_data && n_kidx > r_sched_len, "Key index out of range.")

endmodule

`default_nettype wire

[sim/tb_rc4_keystream_cipher.sv]
`default_nettype none

module tb_rc4_keystream_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    typedef struct packed {
        logic  command;
        t_byte data_byte;
        logic  last;
    } t_cipher_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_command   = CMD_KEY;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last      = 1'b0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [7:0]  o_out_byte;

    rc4_keystream_cipher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte)
    );

    always #5 i_clk = ~i_clk;

    // Cipher state as the block should hold it.
    t_byte       sbox [PERM_DEPTH];
    t_byte       key_bytes [KEY_MAX];
    int unsigned key_count;
    t_byte       gen_i;
    t_byte       gen_j;

    t_cipher_item pending_items [$];
    t_byte        expected_out_bytes [$];
    t_cipher_item next_item;

    int unsigned total_items;
    int unsigned sent_count  = 0;
    int unsigned rx_count    = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned error_count = 0;

    task automatic reset_cipher_state();
        for (int k = 0; k < PERM_DEPTH; k++) begin
            sbox[k]      = t_byte'(k);
            key_bytes[k] = 8'h00;
        end
        key_count = 0;
        gen_i     = 8'h00;
        gen_j     = 8'h00;
    endtask

    task automatic schedule_key(input int unsigned len);
        t_byte j;
        t_byte t;
        j = 8'h00;
        for (int k = 0; k < PERM_DEPTH; k++) begin
            sbox[k] = t_byte'(k);
        end
        for (int k = 0; k < PERM_DEPTH; k++) begin
            j       = j + sbox[k] + key_bytes[k % len];
            t       = sbox[k];
            sbox[k] = sbox[j];
            sbox[j] = t;
        end
        gen_i = 8'h00;
        gen_j = 8'h00;
    endtask

    // Applies one accepted transaction and, for a data byte, records the byte it must produce.
    task automatic cipher_step(input logic command, input t_byte data_byte, input logic last);
        t_byte t;
        t_byte ks_index;
        if (command == CMD_KEY) begin
            if (key_count < KEY_MAX) begin
                key_bytes[key_count] = data_byte;
                key_count++;
            end
            if (last) begin
                schedule_key(key_count);
                key_count = 0;
            end
        end else begin
            gen_i       = gen_i + 8'd1;
            gen_j       = gen_j + sbox[gen_i];
            t           = sbox[gen_i];
            sbox[gen_i] = sbox[gen_j];
            sbox[gen_j] = t;
            ks_index    = sbox[gen_i] + sbox[gen_j];
            expected_out_bytes.push_back(data_byte ^ sbox[ks_index]);
        end
    endtask

    task automatic push_item(input logic command, input t_byte data_byte, input logic last);
        t_cipher_item item;
        item.command   = command;
        item.data_byte = data_byte;
        item.last      = last;
        pending_items.push_back(item);
    endtask

    task automatic queue_data(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            push_item(CMD_DATA, t_byte'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // A key whose final byte carries last, with data bytes optionally mixed in.
    task automatic queue_key(input int unsigned len, input bit mixed);
        for (int unsigned k = 0; k < len; k++) begin
            push_item(CMD_KEY, t_byte'($urandom_range(255)), k == len - 1);
            if (mixed && k != len - 1 && $urandom_range(3) == 0) begin
                queue_data(1);
            end
        end
    endtask

    task automatic report_error(input string what, input t_byte want, input t_byte got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_command   <= CMD_KEY;
            i_data_byte <= 8'h00;
            i_last      <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cipher_step(i_command, i_data_byte, i_last);
                sent_count <= sent_count + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0 &&
                    ((sent_count >= 600 && sent_count < 800) || $urandom_range(99) >= 21)) begin
                    next_item = pending_items.pop_front();
                    i_valid     <= 1'b1;
                    i_command   <= next_item.command;
                    i_data_byte <= next_item.data_byte;
                    i_last      <= next_item.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the output so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && rx_count >= 100) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_out_bytes.size() == 0) begin
                    report_error("output transaction with none pending", 8'h00, o_out_byte);
                end else if (o_out_byte !== expected_out_bytes[0]) begin
                    report_error("out_byte mismatch", expected_out_bytes[0], o_out_byte);
                    void'(expected_out_bytes.pop_front());
                end else begin
                    void'(expected_out_bytes.pop_front());
                end
                rx_count <= rx_count + 1;
            end
            i_stall <= (hold_left != 0) ||
                       (!(rx_count >= 400 && rx_count < 560) && $urandom_range(99) < 21);
        end
    end

    initial begin
        int unsigned n;
        reset_cipher_state();

        // Data before any key runs on the identity permutation.
        push_item(CMD_DATA, 8'h00, 1'b0);
        push_item(CMD_DATA, 8'hFF, 1'b0);
        push_item(CMD_DATA, 8'hA5, 1'b1);
        push_item(CMD_DATA, 8'h5A, 1'b0);
        push_item(CMD_KEY, 8'hFF, 1'b0);
        push_item(CMD_KEY, 8'h00, 1'b0);
        push_item(CMD_KEY, 8'h80, 1'b1);
        push_item(CMD_DATA, 8'h00, 1'b0);
        push_item(CMD_DATA, 8'hFF, 1'b0);
        push_item(CMD_DATA, 8'h3C, 1'b1);
        // Data bytes in the middle of a key load keep the old permutation.
        push_item(CMD_KEY, 8'h12, 1'b0);
        push_item(CMD_DATA, 8'h34, 1'b0);
        push_item(CMD_KEY, 8'h56, 1'b0);
        push_item(CMD_DATA, 8'h78, 1'b1);
        push_item(CMD_KEY, 8'h9A, 1'b1);
        push_item(CMD_DATA, 8'hBC, 1'b0);
        push_item(CMD_DATA, 8'hDE, 1'b0);
        push_item(CMD_KEY, 8'h00, 1'b1);
        push_item(CMD_DATA, 8'hFF, 1'b0);
        push_item(CMD_DATA, 8'h01, 1'b0);
        push_item(CMD_KEY, 8'hFF, 1'b1);
        push_item(CMD_DATA, 8'h80, 1'b0);

        // An overlong key whose last two bytes are dropped, then a key of exactly full length.
        queue_key(258, 1'b0);
        queue_data(8);
        queue_key(KEY_MAX, 1'b0);
        queue_data(8);

        while (pending_items.size() < 1400) begin
            if ($urandom_range(99) < 80) begin
                queue_key($urandom_range(($urandom_range(9) == 0) ? 40 : 16, 1),
                          $urandom_range(4) == 0);
                queue_data($urandom_range(40, 1));
            end else begin
                n = $urandom_range(10, 1);
                for (int unsigned k = 0; k < n; k++) begin
                    push_item(1'($urandom_range(1)), t_byte'($urandom_range(255)),
                              1'($urandom_range(1)));
                end
            end
        end
        total_items = pending_items.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count != total_items) @(posedge i_clk);
        while (expected_out_bytes.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (error_count == 0 && expected_out_bytes.size() == 0) begin
            $display("tb_rc4_keystream_cipher: PASS");
        end else begin
            $display("tb_rc4_keystream_cipher: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_rc4_keystream_cipher: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
